// ===== design/rv32ex_pkg.sv =====
// Shared types, constants and helpers for the RV32IM execute unit.
// Depends on nothing; the controller, datapath, top level and testbench import it.
`timescale 1ns / 1ps

package rv32ex_pkg;

	localparam int unsigned MEM_BYTES = 65536;
	localparam int unsigned MEM_AW = $clog2(MEM_BYTES);

	localparam logic [4:0] SP_INDEX = 5'd2;
	localparam logic [4:0] A0_INDEX = 5'd10;
	localparam logic [31:0] HALT_CODE = 32'd10;
	localparam logic [31:0] SP_RESET = 32'(MEM_BYTES);
	localparam logic [31:0] PC_STEP = 32'd4;

	typedef enum logic [5:0] {
		OP_LB = 6'd0, OP_LH = 6'd1, OP_LW = 6'd2, OP_LBU = 6'd3, OP_LHU = 6'd4,
		OP_FENCE = 6'd5, OP_FENCE_I = 6'd6, OP_ADDI = 6'd7, OP_SLLI = 6'd8,
		OP_SLTI = 6'd9, OP_SLTIU = 6'd10, OP_XORI = 6'd11, OP_SRLI = 6'd12,
		OP_SRAI = 6'd13, OP_ORI = 6'd14, OP_ANDI = 6'd15, OP_AUIPC = 6'd16,
		OP_SB = 6'd17, OP_SH = 6'd18, OP_SW = 6'd19, OP_ADD = 6'd20,
		OP_SUB = 6'd21, OP_SLL = 6'd22, OP_SLT = 6'd23, OP_SLTU = 6'd24,
		OP_XOR = 6'd25, OP_SRL = 6'd26, OP_SRA = 6'd27, OP_OR = 6'd28,
		OP_AND = 6'd29, OP_LUI = 6'd30, OP_BEQ = 6'd31, OP_BNE = 6'd32,
		OP_BLT = 6'd33, OP_BGE = 6'd34, OP_BLTU = 6'd35, OP_BGEU = 6'd36,
		OP_JALR = 6'd37, OP_JAL = 6'd38, OP_ECALL = 6'd39, OP_EBREAK = 6'd40,
		OP_CSRRW = 6'd41, OP_CSRRS = 6'd42, OP_CSRRC = 6'd43, OP_CSRRWI = 6'd44,
		OP_CSRRSI = 6'd45, OP_CSRRCI = 6'd46, OP_MUL = 6'd47, OP_MULH = 6'd48,
		OP_MULHSU = 6'd49, OP_MULHU = 6'd50, OP_DIV = 6'd51, OP_DIVU = 6'd52,
		OP_REM = 6'd53, OP_REMU = 6'd54
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_NOT_IMPL = 2'd1, ST_MEM_RANGE = 2'd2, ST_UNKNOWN = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CLS_SIMPLE, CLS_LOAD, CLS_STORE, CLS_DIV, CLS_ERR
	} cls_t;

	typedef struct packed {
		logic latch;
		logic rf_rd;
		logic exec;
		logic mem_rd;
		logic mem_cap;
		logic mem_wr;
		logic div_step;
		logic commit;
		logic clr;
	} dp_cmd_t;

	typedef struct packed {
		cls_t cls;
		logic byte_last;
		logic div_last;
		logic clr_last;
	} dp_stat_t;

	function automatic logic [31:0] reg_reset_value(input logic [4:0] idx);
		return (idx == SP_INDEX) ? SP_RESET : 32'd0;
	endfunction

endpackage

// ===== design/rv32ex_in_if.sv =====
// Input channel carrying one decoded instruction word.
// Depends on nothing.
`timescale 1ns / 1ps

interface rv32ex_in_if;
	logic valid;
	logic ready;
	logic [5:0] func;
	logic [4:0] dest_index;
	logic [4:0] src1_index;
	logic [4:0] src2_index;
	logic signed [31:0] imm_value;

	modport source(output valid, func, dest_index, src1_index, src2_index, imm_value,
		input ready);
	modport sink(input valid, func, dest_index, src1_index, src2_index, imm_value,
		output ready);
endinterface

// ===== design/rv32ex_out_if.sv =====
// Output channel carrying one execution result word.
// Depends on nothing.
`timescale 1ns / 1ps

interface rv32ex_out_if;
	logic valid;
	logic ready;
	logic [31:0] next_pc;
	logic halt;
	logic [1:0] status;
	logic reg_written;
	logic [4:0] written_index;
	logic [31:0] written_value;

	modport source(output valid, next_pc, halt, status, reg_written, written_index,
		written_value, input ready);
	modport sink(input valid, next_pc, halt, status, reg_written, written_index,
		written_value, output ready);
endinterface

// ===== design/rv32ex_ctrl.sv =====
// Sequencer of the execute unit: clearing pass, operand read, execute,
// memory byte loop, divider loop and writeback. Depends on rv32ex_pkg.
`timescale 1ns / 1ps

module rv32ex_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output rv32ex_pkg::dp_cmd_t cmd,
	input  rv32ex_pkg::dp_stat_t stat
);
	import rv32ex_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MEM_RD, S_MEM_CAP, S_MEM_WR, S_DIV, S_WB
	} state_t;

	state_t state_q;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.clr = (state_q == S_CLEAR);
		cmd.latch = (state_q == S_IDLE) && in_valid;
		cmd.rf_rd = (state_q == S_READ);
		cmd.exec = (state_q == S_EXEC);
		cmd.mem_rd = (state_q == S_MEM_RD);
		cmd.mem_cap = (state_q == S_MEM_CAP);
		cmd.mem_wr = (state_q == S_MEM_WR);
		cmd.div_step = (state_q == S_DIV);
		cmd.commit = (state_q == S_WB) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_WB && slot_free) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: if (stat.clr_last) state_q <= S_IDLE;
				S_IDLE: if (in_valid) state_q <= S_READ;
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					case (stat.cls)
						CLS_LOAD: state_q <= S_MEM_RD;
						CLS_STORE: state_q <= S_MEM_WR;
						CLS_DIV: state_q <= S_DIV;
						default: state_q <= S_WB;
					endcase
				end
				S_MEM_RD: state_q <= S_MEM_CAP;
				S_MEM_CAP: state_q <= stat.byte_last ? S_WB : S_MEM_RD;
				S_MEM_WR: if (stat.byte_last) state_q <= S_WB;
				S_DIV: if (stat.div_last) state_q <= S_WB;
				S_WB: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== design/rv32ex_dpath.sv =====
// Datapath of the execute unit: register file, pc, byte memory, ALU,
// multiplier and restoring divider. Depends on rv32ex_pkg.
`timescale 1ns / 1ps

module rv32ex_dpath (
	input  logic clk,
	input  logic arst_n,
	input  rv32ex_pkg::dp_cmd_t cmd,
	output rv32ex_pkg::dp_stat_t stat,
	input  logic [5:0] func,
	input  logic [4:0] dest_index,
	input  logic [4:0] src1_index,
	input  logic [4:0] src2_index,
	input  logic [31:0] imm_value,
	output logic [31:0] next_pc,
	output logic halt,
	output logic [1:0] status,
	output logic reg_written,
	output logic [4:0] written_index,
	output logic [31:0] written_value
);
	import rv32ex_pkg::*;

	logic [31:0] rf_q [32];
	logic [31:0] rv_q;
	logic [7:0] mem_q [MEM_BYTES];
	logic [MEM_AW-1:0] clr_cnt_q;

	logic [5:0] func_q;
	logic [4:0] dest_q, src1_q, src2_q;
	logic [31:0] imm_q, a_q, b_q, pc_q;

	logic [31:0] val_q, npc_q, addr_q;
	logic wr_q, halt_q, lsign_q;
	status_t status_q;
	cls_t cls_q;
	logic [2:0] size_q;
	logic [1:0] cnt_q;
	logic [31:0] ld_q;
	logic [7:0] rdata_q;

	logic [31:0] quo_q, rem_q, dvs_q, dvd_q;
	logic [4:0] dcnt_q;
	logic isrem_q, negq_q, negr_q, bzero_q;

	logic [4:0] ra_idx;
	op_t op;
	cls_t e_cls;
	status_t e_status;
	logic [31:0] e_val, e_npc, sum_ai;
	logic e_wr, e_halt, e_sa, e_sb, e_lsign, taken, range_ok;
	logic [2:0] e_size;
	logic signed [65:0] prod;
	logic [32:0] div_t;
	logic [31:0] byte_addr, ld_val, div_val, wb_val;
	logic e_dsigned;
	logic commit_wr;

	assign op = op_t'(func_q);
	assign ra_idx = (op == OP_ECALL) ? A0_INDEX : src1_q;
	assign sum_ai = a_q + imm_q;
	assign byte_addr = addr_q + 32'(cnt_q);

	always_comb begin
		e_sa = (op == OP_MULH) || (op == OP_MULHSU);
		e_sb = (op == OP_MULH);
		prod = $signed({e_sa & a_q[31], a_q}) * $signed({e_sb & b_q[31], b_q});
	end

	always_comb begin
		e_cls = CLS_SIMPLE;
		e_status = ST_OK;
		e_val = '0;
		e_wr = 1'b0;
		e_halt = 1'b0;
		e_size = 3'd0;
		e_lsign = 1'b0;
		e_npc = pc_q + PC_STEP;
		taken = 1'b0;
		case (op)
			OP_LB, OP_LBU: e_size = 3'd1;
			OP_LH, OP_LHU, OP_SH: e_size = 3'd2;
			OP_SB: e_size = 3'd1;
			default: e_size = 3'd4;
		endcase
		range_ok = !sum_ai[31] && (({1'b0, sum_ai} + 33'(e_size)) <= 33'(MEM_BYTES));
		case (op)
			OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
				e_cls = range_ok ? CLS_LOAD : CLS_ERR;
				e_status = range_ok ? ST_OK : ST_MEM_RANGE;
				e_lsign = (op == OP_LB) || (op == OP_LH);
				e_wr = 1'b1;
			end
			OP_SB, OP_SH, OP_SW: begin
				e_cls = range_ok ? CLS_STORE : CLS_ERR;
				e_status = range_ok ? ST_OK : ST_MEM_RANGE;
			end
			OP_FENCE, OP_FENCE_I, OP_CSRRW, OP_CSRRS, OP_CSRRC, OP_CSRRWI, OP_CSRRSI,
			OP_CSRRCI: begin
				e_cls = CLS_ERR;
				e_status = ST_NOT_IMPL;
			end
			OP_ADDI: begin e_val = sum_ai; e_wr = 1'b1; end
			OP_SLLI: begin e_val = a_q << imm_q[4:0]; e_wr = 1'b1; end
			OP_SLTI: begin e_val = {31'd0, $signed(a_q) < $signed(imm_q)}; e_wr = 1'b1; end
			OP_SLTIU: begin e_val = {31'd0, a_q < imm_q}; e_wr = 1'b1; end
			OP_XORI: begin e_val = a_q ^ imm_q; e_wr = 1'b1; end
			OP_SRLI: begin e_val = a_q >> imm_q[4:0]; e_wr = 1'b1; end
			OP_SRAI: begin e_val = 32'($signed(a_q) >>> imm_q[4:0]); e_wr = 1'b1; end
			OP_ORI: begin e_val = a_q | imm_q; e_wr = 1'b1; end
			OP_ANDI: begin e_val = a_q & imm_q; e_wr = 1'b1; end
			OP_AUIPC: begin e_val = pc_q + imm_q; e_wr = 1'b1; end
			OP_ADD: begin e_val = a_q + b_q; e_wr = 1'b1; end
			OP_SUB: begin e_val = a_q - b_q; e_wr = 1'b1; end
			OP_SLL: begin e_val = a_q << b_q[4:0]; e_wr = 1'b1; end
			OP_SLT: begin e_val = {31'd0, $signed(a_q) < $signed(b_q)}; e_wr = 1'b1; end
			OP_SLTU: begin e_val = {31'd0, a_q < b_q}; e_wr = 1'b1; end
			OP_XOR: begin e_val = a_q ^ b_q; e_wr = 1'b1; end
			OP_SRL: begin e_val = a_q >> b_q[4:0]; e_wr = 1'b1; end
			OP_SRA: begin e_val = 32'($signed(a_q) >>> b_q[4:0]); e_wr = 1'b1; end
			OP_OR: begin e_val = a_q | b_q; e_wr = 1'b1; end
			OP_AND: begin e_val = a_q & b_q; e_wr = 1'b1; end
			OP_LUI: begin e_val = imm_q; e_wr = 1'b1; end
			OP_BEQ: taken = (a_q == b_q);
			OP_BNE: taken = (a_q != b_q);
			OP_BLT: taken = $signed(a_q) < $signed(b_q);
			OP_BGE: taken = !($signed(a_q) < $signed(b_q));
			OP_BLTU: taken = (a_q < b_q);
			OP_BGEU: taken = (a_q >= b_q);
			OP_JALR: begin
				e_val = pc_q + PC_STEP;
				e_wr = 1'b1;
				e_npc = {sum_ai[31:1], 1'b0};
			end
			OP_JAL: begin
				e_val = pc_q + PC_STEP;
				e_wr = 1'b1;
				e_npc = pc_q + imm_q;
			end
			OP_ECALL: e_halt = (a_q == HALT_CODE);
			OP_EBREAK: e_wr = 1'b0;
			OP_MUL: begin e_val = prod[31:0]; e_wr = 1'b1; end
			OP_MULH, OP_MULHSU, OP_MULHU: begin e_val = prod[63:32]; e_wr = 1'b1; end
			OP_DIV, OP_DIVU, OP_REM, OP_REMU: begin e_cls = CLS_DIV; e_wr = 1'b1; end
			default: begin
				e_cls = CLS_ERR;
				e_status = ST_UNKNOWN;
			end
		endcase
		if (taken) e_npc = pc_q + imm_q;
		if (e_status != ST_OK) begin
			e_npc = pc_q;
			e_wr = 1'b0;
			e_halt = 1'b0;
		end
	end

	assign e_dsigned = (op == OP_DIV) || (op == OP_REM);
	assign div_t = {rem_q, quo_q[31]};

	always_comb begin
		case (size_q)
			3'd1: ld_val = {{24{lsign_q & ld_q[7]}}, ld_q[7:0]};
			3'd2: ld_val = {{16{lsign_q & ld_q[15]}}, ld_q[15:0]};
			default: ld_val = ld_q;
		endcase
		if (bzero_q) div_val = isrem_q ? dvd_q : '1;
		else if (isrem_q) div_val = negr_q ? -rem_q : rem_q;
		else div_val = negq_q ? -quo_q : quo_q;
		case (cls_q)
			CLS_LOAD: wb_val = ld_val;
			CLS_DIV: wb_val = div_val;
			default: wb_val = val_q;
		endcase
	end

	assign commit_wr = (status_q == ST_OK) && wr_q && (dest_q != 5'd0);

	assign stat.cls = e_cls;
	assign stat.byte_last = ((3'(cnt_q) + 3'd1) == size_q);
	assign stat.div_last = (dcnt_q == 5'd31);
	assign stat.clr_last = (clr_cnt_q == MEM_AW'(MEM_BYTES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= '0;
			pc_q <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.clr) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.commit && status_q == ST_OK) pc_q <= npc_q;
			if (cmd.commit && commit_wr) rv_q[dest_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && commit_wr) rf_q[dest_q] <= wb_val;
		if (cmd.rf_rd) begin
			a_q <= rv_q[ra_idx] ? rf_q[ra_idx] : reg_reset_value(ra_idx);
			b_q <= rv_q[src2_q] ? rf_q[src2_q] : reg_reset_value(src2_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) mem_q[clr_cnt_q] <= '0;
		else if (cmd.mem_wr) mem_q[byte_addr[MEM_AW-1:0]] <= b_q[8*cnt_q +: 8];
		if (cmd.mem_rd) rdata_q <= mem_q[byte_addr[MEM_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= func;
			dest_q <= dest_index;
			src1_q <= src1_index;
			src2_q <= src2_index;
			imm_q <= imm_value;
		end
		if (cmd.exec) begin
			val_q <= e_val;
			wr_q <= e_wr;
			halt_q <= e_halt;
			npc_q <= e_npc;
			status_q <= e_status;
			cls_q <= e_cls;
			size_q <= e_size;
			lsign_q <= e_lsign;
			addr_q <= sum_ai;
			cnt_q <= '0;
			ld_q <= '0;
			quo_q <= (e_dsigned && a_q[31]) ? -a_q : a_q;
			rem_q <= '0;
			dvs_q <= (e_dsigned && b_q[31]) ? -b_q : b_q;
			dvd_q <= a_q;
			dcnt_q <= '0;
			isrem_q <= (op == OP_REM) || (op == OP_REMU);
			negq_q <= e_dsigned && (a_q[31] ^ b_q[31]);
			negr_q <= e_dsigned && a_q[31];
			bzero_q <= (b_q == 32'd0);
		end
		if (cmd.mem_cap) begin
			ld_q[8*cnt_q +: 8] <= rdata_q;
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.mem_wr) cnt_q <= cnt_q + 1'b1;
		if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 1'b1;
			if (div_t >= {1'b0, dvs_q}) begin
				rem_q <= 32'(div_t - {1'b0, dvs_q});
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= div_t[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (cmd.commit) begin
			next_pc <= npc_q;
			halt <= halt_q;
			status <= status_q;
			reg_written <= commit_wr;
			written_index <= commit_wr ? dest_q : 5'd0;
			written_value <= commit_wr ? wb_val : 32'd0;
		end
	end
endmodule

// ===== design/rv32ex_execute_unit_top.sv =====
`timescale 1ns / 1ps
// Top level of the RV32IM execute unit; joins rv32ex_ctrl and rv32ex_dpath.
// Depends on rv32ex_pkg, rv32ex_in_if and rv32ex_out_if.
//
// Channel  Direction  Word
// cmd      in         func, dest_index, src1_index, src2_index, imm_value
// res      out        next_pc, halt, status, reg_written, written_index, written_value
//
// One instruction at a time: ALU, multiply, branch, jump and error words pass through operand
// read, execute and writeback. Loads add a read and a capture per byte, stores a write per
// byte (byte-wide memory port). Divide and remainder add the steps of the restoring divider.
// After reset the data memory is cleared, one byte a cycle, while cmd.ready stays low.
// A stalled result holds in the output register.

module rv32im_execute_unit_top (
	input logic clk,
	input logic arst_n,
	rv32ex_in_if.sink cmd,
	rv32ex_out_if.source res
);
	import rv32ex_pkg::*;

	dp_cmd_t dcmd;
	dp_stat_t dstat;

	rv32ex_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(cmd.valid),
		.in_ready(cmd.ready),
		.out_valid(res.valid),
		.out_ready(res.ready),
		.cmd(dcmd),
		.stat(dstat)
	);

	rv32ex_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(dcmd),
		.stat(dstat),
		.func(cmd.func),
		.dest_index(cmd.dest_index),
		.src1_index(cmd.src1_index),
		.src2_index(cmd.src2_index),
		.imm_value(cmd.imm_value),
		.next_pc(res.next_pc),
		.halt(res.halt),
		.status(res.status),
		.reg_written(res.reg_written),
		.written_index(res.written_index),
		.written_value(res.written_value)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("input accepted while an instruction is in flight");

	a_error_no_effect: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status != ST_OK) |-> (!res.reg_written && !res.halt))
		else $error("error result reports a write or a halt");

	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.reg_written) |-> (res.written_index != 5'd0))
		else $error("write reported to register zero");

	a_commit_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.commit |-> (!res.valid || res.ready))
		else $error("result overwritten before it was taken");
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rv32im_execute_unit_top: directed instruction table, then random
// programs, checked against typed table words or an in-bench model. Depends on rv32ex_pkg.

module tb;
	import rv32ex_pkg::*;

	typedef struct packed {
		logic [5:0] func;
		logic [4:0] rd;
		logic [4:0] rs1;
		logic [4:0] rs2;
		logic [31:0] imm;
	} instr_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic halt;
		logic [1:0] status;
		logic reg_written;
		logic [4:0] written_index;
		logic [31:0] written_value;
	} outcome_t;

	typedef struct packed {
		instr_t ins;
		logic typed;
		outcome_t exp;
	} row_t;

	localparam int RANDOM_ITEMS = 1850;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rv32ex_in_if cmd();
	rv32ex_out_if res();

	rv32im_execute_unit_top dut (.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res));

	always #5 clk = ~clk;

	logic [31:0] regs [0:31];
	logic [31:0] pc_model;
	logic [7:0] mem_model [0:MEM_BYTES-1];

	outcome_t pending [$];
	row_t directed [$];
	int errors = 0;
	int words_checked = 0;
	int halts_seen = 0;
	int errs_seen = 0;
	longint cycles = 0;

	function automatic logic addr_ok(input logic [31:0] addr, input int size);
		return !addr[31] && (longint'(addr) + size <= longint'(MEM_BYTES));
	endfunction

	function automatic outcome_t execute(input instr_t ins);
		outcome_t o;
		logic [31:0] a, b, imm, val, npc, addr;
		logic [63:0] prod;
		logic wr, taken;
		logic [1:0] st;
		int size;
		a = regs[ins.rs1];
		b = regs[ins.rs2];
		imm = ins.imm;
		npc = pc_model + PC_STEP;
		addr = a + imm;
		val = '0;
		wr = 1'b0;
		taken = 1'b0;
		st = ST_OK;
		o = '0;
		size = 0;
		case (ins.func)
			OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
				size = (ins.func == OP_LW) ? 4 :
					(ins.func == OP_LB || ins.func == OP_LBU) ? 1 : 2;
				if (!addr_ok(addr, size)) begin
					st = ST_MEM_RANGE;
				end else begin
					for (int i = 0; i < size; i++) val |= 32'(mem_model[addr + i]) << (8 * i);
					if (ins.func == OP_LB) val = {{24{val[7]}}, val[7:0]};
					if (ins.func == OP_LH) val = {{16{val[15]}}, val[15:0]};
					wr = 1'b1;
				end
			end
			OP_SB, OP_SH, OP_SW: begin
				size = (ins.func == OP_SB) ? 1 : (ins.func == OP_SH) ? 2 : 4;
				if (!addr_ok(addr, size)) begin
					st = ST_MEM_RANGE;
				end else begin
					for (int i = 0; i < size; i++) mem_model[addr + i] = b[8 * i +: 8];
				end
			end
			OP_FENCE, OP_FENCE_I, OP_CSRRW, OP_CSRRS, OP_CSRRC, OP_CSRRWI, OP_CSRRSI,
			OP_CSRRCI: st = ST_NOT_IMPL;
			OP_ADDI: begin val = a + imm; wr = 1'b1; end
			OP_SLLI: begin val = a << imm[4:0]; wr = 1'b1; end
			OP_SLTI: begin val = 32'($signed(a) < $signed(imm)); wr = 1'b1; end
			OP_SLTIU: begin val = 32'(a < imm); wr = 1'b1; end
			OP_XORI: begin val = a ^ imm; wr = 1'b1; end
			OP_SRLI: begin val = a >> imm[4:0]; wr = 1'b1; end
			OP_SRAI: begin val = $signed(a) >>> imm[4:0]; wr = 1'b1; end
			OP_ORI: begin val = a | imm; wr = 1'b1; end
			OP_ANDI: begin val = a & imm; wr = 1'b1; end
			OP_AUIPC: begin val = pc_model + imm; wr = 1'b1; end
			OP_ADD: begin val = a + b; wr = 1'b1; end
			OP_SUB: begin val = a - b; wr = 1'b1; end
			OP_SLL: begin val = a << b[4:0]; wr = 1'b1; end
			OP_SLT: begin val = 32'($signed(a) < $signed(b)); wr = 1'b1; end
			OP_SLTU: begin val = 32'(a < b); wr = 1'b1; end
			OP_XOR: begin val = a ^ b; wr = 1'b1; end
			OP_SRL: begin val = a >> b[4:0]; wr = 1'b1; end
			OP_SRA: begin val = $signed(a) >>> b[4:0]; wr = 1'b1; end
			OP_OR: begin val = a | b; wr = 1'b1; end
			OP_AND: begin val = a & b; wr = 1'b1; end
			OP_LUI: begin val = imm; wr = 1'b1; end
			OP_BEQ: taken = (a == b);
			OP_BNE: taken = (a != b);
			OP_BLT: taken = $signed(a) < $signed(b);
			OP_BGE: taken = !($signed(a) < $signed(b));
			OP_BLTU: taken = a < b;
			OP_BGEU: taken = a >= b;
			OP_JALR: begin val = pc_model + PC_STEP; wr = 1'b1; npc = (a + imm) & ~32'd1; end
			OP_JAL: begin val = pc_model + PC_STEP; wr = 1'b1; npc = pc_model + imm; end
			OP_ECALL: o.halt = (regs[A0_INDEX] == HALT_CODE);
			OP_EBREAK: ;
			OP_MUL: begin val = a * b; wr = 1'b1; end
			OP_MULH: begin
				prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
				val = prod[63:32];
				wr = 1'b1;
			end
			OP_MULHSU: begin
				prod = {{32{a[31]}}, a} * {32'd0, b};
				val = prod[63:32];
				wr = 1'b1;
			end
			OP_MULHU: begin
				prod = {32'd0, a} * {32'd0, b};
				val = prod[63:32];
				wr = 1'b1;
			end
			OP_DIV: begin
				if (b == 0) val = '1;
				else if (a == 32'h8000_0000 && b == '1) val = a;
				else val = $signed(a) / $signed(b);
				wr = 1'b1;
			end
			OP_DIVU: begin val = (b == 0) ? '1 : a / b; wr = 1'b1; end
			OP_REM: begin
				if (b == 0) val = a;
				else if (a == 32'h8000_0000 && b == '1) val = '0;
				else val = $signed(a) % $signed(b);
				wr = 1'b1;
			end
			OP_REMU: begin val = (b == 0) ? a : a % b; wr = 1'b1; end
			default: st = ST_UNKNOWN;
		endcase
		if (taken) npc = pc_model + imm;
		if (st != ST_OK) begin
			npc = pc_model;
			wr = 1'b0;
			o.halt = 1'b0;
		end else begin
			pc_model = npc;
			if (wr && ins.rd != 0) regs[ins.rd] = val;
		end
		o.next_pc = npc;
		o.status = st;
		if (wr && ins.rd != 0) begin
			o.reg_written = 1'b1;
			o.written_index = ins.rd;
			o.written_value = val;
		end
		return o;
	endfunction

	function automatic instr_t random_instr();
		instr_t ins;
		int pick, size;
		logic [31:0] target;
		ins.rd = 5'($urandom);
		ins.rs1 = 5'($urandom);
		ins.rs2 = 5'($urandom);
		ins.imm = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			case ($urandom_range(0, 7))
				0: ins.func = OP_LB;
				1: ins.func = OP_LH;
				2: ins.func = OP_LW;
				3: ins.func = OP_LBU;
				4: ins.func = OP_LHU;
				5: ins.func = OP_SB;
				6: ins.func = OP_SH;
				default: ins.func = OP_SW;
			endcase
			size = (ins.func inside {OP_LW, OP_SW}) ? 4 :
				(ins.func inside {OP_LB, OP_LBU, OP_SB}) ? 1 : 2;
			if ($urandom_range(0, 9) == 0) target = $urandom;
			else if ($urandom_range(0, 3) == 0)
				target = $urandom_range(MEM_BYTES - 6, MEM_BYTES - size);
			else target = $urandom_range(0, 63);
			ins.imm = target - regs[ins.rs1];
		end else if (pick < 45) begin
			ins.func = 6'($urandom_range(OP_MUL, OP_REMU));
			if ($urandom_range(0, 4) == 0) ins.rs2 = 5'd0;
		end else if (pick < 50) begin
			ins.func = 6'($urandom_range(0, 63));
		end else if (pick < 54) begin
			ins.func = OP_ADDI;
			ins.rd = A0_INDEX;
			ins.rs1 = 5'd0;
			ins.imm = HALT_CODE;
		end else if (pick < 58) begin
			ins.func = OP_ECALL;
		end else if (pick < 66) begin
			ins.func = 6'($urandom_range(OP_BEQ, OP_JAL));
			if ($urandom_range(0, 3) == 0) ins.rs2 = ins.rs1;
		end else begin
			ins.func = 6'($urandom_range(OP_ADDI, OP_LUI));
			if (ins.func inside {OP_SB, OP_SH, OP_SW}) ins.func = OP_LUI;
			if ($urandom_range(0, 3) == 0) ins.imm = $signed(12'($urandom));
		end
		return ins;
	endfunction

	task automatic issue(input instr_t ins, input logic typed, input outcome_t exp);
		int gap;
		logic rdy;
		outcome_t pred;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pred = execute(ins);
		pending.push_back(typed ? exp : pred);
		cmd.valid <= 1'b1;
		cmd.func <= ins.func;
		cmd.dest_index <= ins.rd;
		cmd.src1_index <= ins.rs1;
		cmd.src2_index <= ins.rs2;
		cmd.imm_value <= ins.imm;
		do begin
			@(negedge clk);
			rdy = cmd.ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	task automatic add_row(input op_t f, input int rd, input int rs1, input int rs2,
		input logic [31:0] imm, input logic typed, input outcome_t exp);
		row_t r;
		r.ins = '{func: f, rd: 5'(rd), rs1: 5'(rs1), rs2: 5'(rs2), imm: imm};
		r.typed = typed;
		r.exp = exp;
		directed.push_back(r);
	endtask

	initial begin
		cmd.valid = 1'b0;
		cmd.func = '0;
		cmd.dest_index = '0;
		cmd.src1_index = '0;
		cmd.src2_index = '0;
		cmd.imm_value = '0;
		res.ready = 1'b0;
		for (int i = 0; i < 32; i++) regs[i] = reg_reset_value(5'(i));
		for (int i = 0; i < MEM_BYTES; i++) mem_model[i] = '0;
		pc_model = '0;

		add_row(OP_ADDI, 1, 0, 0, '1, 1, '{32'd4, 1'b0, ST_OK, 1'b1, 5'd1, 32'hFFFF_FFFF});
		add_row(OP_ADD, 3, 2, 0, 0, 1, '{32'd8, 1'b0, ST_OK, 1'b1, 5'd3, SP_RESET});
		add_row(OP_LUI, 0, 0, 0, 32'h7FFF_F000, 1, '{32'd12, 1'b0, ST_OK, 1'b0, 5'd0, 32'd0});
		add_row(OP_SW, 0, 2, 1, -32'sd4, 1, '{32'd16, 1'b0, ST_OK, 1'b0, 5'd0, 32'd0});
		add_row(OP_LW, 4, 2, 0, -32'sd4, 1, '{32'd20, 1'b0, ST_OK, 1'b1, 5'd4, 32'hFFFF_FFFF});
		add_row(OP_LB, 5, 2, 0, 0, 1, '{32'd20, 1'b0, ST_MEM_RANGE, 1'b0, 5'd0, 32'd0});
		add_row(OP_LW, 5, 0, 0, '1, 1, '{32'd20, 1'b0, ST_MEM_RANGE, 1'b0, 5'd0, 32'd0});
		add_row(OP_FENCE, 5, 0, 0, 0, 1, '{32'd20, 1'b0, ST_NOT_IMPL, 1'b0, 5'd0, 32'd0});
		add_row(OP_CSRRCI, 5, 0, 0, 0, 1, '{32'd20, 1'b0, ST_NOT_IMPL, 1'b0, 5'd0, 32'd0});
		add_row(op_t'(6'd63), 5, 0, 0, 0, 1, '{32'd20, 1'b0, ST_UNKNOWN, 1'b0, 5'd0, 32'd0});
		add_row(OP_SH, 0, 0, 1, 0, 0, '0);
		add_row(OP_LBU, 6, 2, 0, -32'sd1, 0, '0);
		add_row(OP_LH, 7, 0, 0, 0, 0, '0);
		add_row(OP_LHU, 7, 2, 0, -32'sd2, 0, '0);
		add_row(OP_LUI, 9, 0, 0, 32'h8000_0000, 0, '0);
		add_row(OP_DIV, 8, 9, 1, 0, 0, '0);
		add_row(OP_REM, 8, 9, 1, 0, 0, '0);
		add_row(OP_DIVU, 8, 1, 0, 0, 0, '0);
		add_row(OP_REMU, 8, 9, 0, 0, 0, '0);
		add_row(OP_MULHSU, 8, 1, 9, 0, 0, '0);
		add_row(OP_SRA, 8, 9, 1, 0, 0, '0);
		add_row(OP_ADDI, 10, 0, 0, HALT_CODE, 0, '0);
		add_row(OP_ECALL, 0, 0, 0, 0, 0, '0);
		add_row(OP_EBREAK, 0, 0, 0, 0, 0, '0);
		add_row(OP_JALR, 8, 1, 0, 32'd3, 0, '0);
		add_row(OP_JAL, 1, 0, 0, -32'sd8, 0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed[i]) issue(directed[i].ins, directed[i].typed, directed[i].exp);
		for (int n = 0; n < RANDOM_ITEMS; n++) issue(random_instr(), 1'b0, '0);
		cmd.valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		$display("Ran %0d instruction words in %0d cycles: %0d halts, %0d error statuses.",
			words_checked, cycles, halts_seen, errs_seen);
		if (errors == 0) begin
			$display("** rv32im_execute_unit_top: PASSED **");
		end else begin
			$display("** rv32im_execute_unit_top: FAILED **");
		end
		$finish;
	end

	initial begin : result_sink
		int stall;
		logic seen;
		outcome_t got, exp;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			do begin
				@(negedge clk);
				seen = res.valid && res.ready;
				got = '{res.next_pc, res.halt, res.status, res.reg_written, res.written_index,
					res.written_value};
				@(posedge clk);
			end while (!seen);
			words_checked++;
			if (got.halt) halts_seen++;
			if (got.status != ST_OK) errs_seen++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result word with none expected: %h", $time, got);
			end else begin
				exp = pending.pop_front();
				if (got.next_pc !== exp.next_pc) begin
					errors++;
					$display("%0t: next_pc expected %h got %h", $time, exp.next_pc, got.next_pc);
				end
				if (got.halt !== exp.halt) begin
					errors++;
					$display("%0t: halt expected %b got %b", $time, exp.halt, got.halt);
				end
				if (got.status !== exp.status) begin
					errors++;
					$display("%0t: status expected %0d got %0d", $time, exp.status, got.status);
				end
				if (got.reg_written !== exp.reg_written) begin
					errors++;
					$display("%0t: reg_written expected %b got %b", $time, exp.reg_written,
						got.reg_written);
				end
				if (got.written_index !== exp.written_index) begin
					errors++;
					$display("%0t: written_index expected %0d got %0d", $time,
						exp.written_index, got.written_index);
				end
				if (got.written_value !== exp.written_value) begin
					errors++;
					$display("%0t: written_value expected %h got %h", $time,
						exp.written_value, got.written_value);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: run did not finish, %0d words still expected", $time, pending.size());
			$display("** rv32im_execute_unit_top: FAILED **");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
design/rv32ex_pkg.sv
design/rv32ex_in_if.sv
design/rv32ex_out_if.sv
design/rv32ex_ctrl.sv
design/rv32ex_dpath.sv
design/rv32ex_execute_unit_top.sv
tb/tb.sv
